>>> hw/rtl/kiat_pkg.sv
// ----------------------------------------------------------------------------
// kiat_pkg
// Shared types and constants for the key/index associative table.
// ----------------------------------------------------------------------------
package kiat_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CNT_OUT_W = 7;

  localparam logic [KEY_W-1:0] KEY_INVALID = '1;
  localparam logic [VAL_W-1:0] VAL_NONE = '1;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_FIND   = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic load;
    logic scan;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

>>> hw/rtl/kiat_ctrl.sv
// ----------------------------------------------------------------------------
// kiat_ctrl
// Request sequencer: accept, scan stored entries, emit result.
// ----------------------------------------------------------------------------
module kiat_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  kiat_pkg::sts_t sts,
  output kiat_pkg::cmd_t cmd
);
  import kiat_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.scan = (state == S_SCAN);
    cmd.emit = (state == S_FIN) && sts.out_free;
    in_stall = (state != S_IDLE);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/kiat_dp.sv
// ----------------------------------------------------------------------------
// kiat_dp
// Key/value storage, scan pointer, compare stage and result register.
// ----------------------------------------------------------------------------
module kiat_dp #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  kiat_pkg::cmd_t              cmd,
  output kiat_pkg::sts_t              sts,
  input  logic                        req_type,
  input  logic [kiat_pkg::KEY_W-1:0]  key,
  input  logic [kiat_pkg::VAL_W-1:0]  value_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        found,
  output logic [kiat_pkg::VAL_W-1:0]  value_out,
  output logic [1:0]                  status,
  output logic [kiat_pkg::CNT_OUT_W-1:0] entry_count
);
  import kiat_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

  logic             req_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic             bad_r;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    fill;
  logic             rd_pend;
  logic [KEY_W-1:0] rd_key;
  logic [VAL_W-1:0] rd_val;
  logic             hit;
  logic [VAL_W-1:0] hit_val;

  logic             issue;
  logic             match;
  logic             full;
  logic             store;
  logic             res_found;
  logic [VAL_W-1:0] res_val;
  logic [1:0]       res_status;
  logic [CW-1:0]    fill_plus;
  logic [CW+CNT_OUT_W-1:0] cnt_ext;

  assign issue = cmd.scan && (idx < fill);
  assign match = cmd.scan && rd_pend && (rd_key == key_r) && !hit;
  assign full  = (fill == CW'(TABLE_DEPTH));

  always_comb begin
    sts.scan_done = bad_r || match || (idx == fill);
    sts.out_free  = !out_valid || !out_stall;
  end

  always_comb begin
    res_found  = 1'b0;
    res_val    = VAL_NONE;
    res_status = ST_OK;
    store      = 1'b0;
    if (bad_r) begin
      res_status = ST_INVALID;
    end else if (req_r == REQ_FIND) begin
      res_found = hit;
      if (hit) res_val = hit_val;
    end else if (hit) begin
      res_found  = 1'b1;
      res_val    = hit_val;
      res_status = ST_DUP;
    end else if (full) begin
      res_status = ST_FULL;
    end else begin
      store     = 1'b1;
      res_found = 1'b1;
      res_val   = val_r;
    end
    fill_plus = fill + CW'(store);
    cnt_ext   = (CW + CNT_OUT_W)'(fill_plus);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= req_type;
      key_r <= key;
      val_r <= value_in;
      bad_r <= (key == KEY_INVALID) || ((req_type == REQ_APPEND) && (value_in == VAL_NONE));
    end
    if (match) hit_val <= rd_val;
    if (cmd.emit) begin
      found       <= res_found;
      value_out   <= res_val;
      status      <= res_status;
      entry_count <= cnt_ext[CNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && store) begin
      key_mem[fill[AW-1:0]] <= key_r;
      val_mem[fill[AW-1:0]] <= val_r;
    end
    if (issue) begin
      rd_key <= key_mem[idx[AW-1:0]];
      rd_val <= val_mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      fill      <= '0;
      rd_pend   <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx     <= '0;
        rd_pend <= 1'b0;
        hit     <= 1'b0;
      end else begin
        idx     <= idx + CW'(issue);
        rd_pend <= issue;
        if (match) hit <= 1'b1;
      end
      if (cmd.emit) fill <= fill_plus;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> hw/rtl/key_index_assoc_table.sv
// ----------------------------------------------------------------------------
// key_index_assoc_table
// Fixed-capacity key-to-index map with in-order linear search.
// ----------------------------------------------------------------------------
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   in      | in_valid / in_stall  | req_type, key, value_in
//   out     | out_valid / out_stall| found, value_out, status, entry_count
//
// Each item scans the stored entries in order, one stored entry compared per
// cycle through the registered read port of the key/value memory; a hit ends
// the scan early and an invalid key skips it.
// Reset clears the fill count; memory contents are not cleared.
// A finished result waits in the output register while the next item is
// accepted; its result is held until out_stall drops.
// ----------------------------------------------------------------------------
module key_index_assoc_table #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [kiat_pkg::KEY_W-1:0]     key,
  input  logic [kiat_pkg::VAL_W-1:0]     value_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic [kiat_pkg::VAL_W-1:0]     value_out,
  output logic [1:0]                     status,
  output logic [kiat_pkg::CNT_OUT_W-1:0] entry_count
);
  import kiat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  kiat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kiat_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .req_type    (req_type),
    .key         (key),
    .value_in    (value_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .value_out   (value_out),
    .status      (status),
    .entry_count (entry_count)
  );

endmodule

>>> hw/rtl/kiat_checker.sv
// ----------------------------------------------------------------------------
// kiat_checker
// Port-level checks for the key/index associative table.
// ----------------------------------------------------------------------------
module kiat_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           found,
  input logic [kiat_pkg::VAL_W-1:0]     value_out,
  input logic [1:0]                     status,
  input logic [kiat_pkg::CNT_OUT_W-1:0] entry_count
);
  import kiat_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while previous one still in work");

  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> value_out == VAL_NONE)
    else $error("not-found result carries a value");

  a_dup_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DUP) |-> found)
    else $error("duplicate status without found");

  a_fail_not_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL || status == ST_INVALID) |-> !found)
    else $error("dropped or invalid item reported found");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(entry_count))
    else $error("stalled result changed");

endmodule

bind key_index_assoc_table kiat_checker u_kiat_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .found       (found),
  .value_out   (value_out),
  .status      (status),
  .entry_count (entry_count)
);

>>> tb/key_index_assoc_table_test.sv
// ----------------------------------------------------------------------------
// key_index_assoc_table_test
// Self-checking bench for the key/index associative table: directed
// find/append corner cases, then random request mixes that fill the
// table, then a full-table pass. Results are compared in order.
// ----------------------------------------------------------------------------
module key_index_assoc_table_test;
  import kiat_pkg::*;

  localparam int DEPTH = 64;
  localparam int IDLE_LIMIT = 2000;

  typedef struct packed {
    logic                 found;
    logic [VAL_W-1:0]     value;
    logic [1:0]           status;
    logic [CNT_OUT_W-1:0] count;
  } lookup_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 req_type = REQ_FIND;
  logic [KEY_W-1:0]     key = '0;
  logic [VAL_W-1:0]     value_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 found;
  logic [VAL_W-1:0]     value_out;
  logic [1:0]           status;
  logic [CNT_OUT_W-1:0] entry_count;

  logic [KEY_W-1:0] stored_keys [DEPTH];
  logic [VAL_W-1:0] stored_vals [DEPTH];
  int               stored_count = 0;

  lookup_result_t pending_results [$];
  int errors = 0;
  int tx_max_gap = 3;
  int rx_max_hold = 3;
  int hold_left = 0;
  int idle_cycles = 0;

  key_index_assoc_table #(.TABLE_DEPTH(DEPTH)) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .key         (key),
    .value_in    (value_in),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .value_out   (value_out),
    .status      (status),
    .entry_count (entry_count)
  );

  always #6 clk = ~clk;

  function automatic int slot_of(logic [KEY_W-1:0] k);
    for (int i = 0; i < stored_count; i++) begin
      if (stored_keys[i] == k) return i;
    end
    return -1;
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [KEY_W-1:0] k;
    do k = $urandom; while (k == KEY_INVALID || slot_of(k) >= 0);
    return k;
  endfunction

  // predict, then hold the item on the bus until it is taken
  task automatic send_request(input logic req, input logic [KEY_W-1:0] k,
                              input logic [VAL_W-1:0] v);
    int gap;
    int slot;
    lookup_result_t want;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    want.found = 1'b0;
    want.value = VAL_NONE;
    want.status = ST_OK;
    slot = slot_of(k);
    if (k == KEY_INVALID) begin
      want.status = ST_INVALID;
    end else if (req == REQ_FIND) begin
      if (slot >= 0) begin
        want.found = 1'b1;
        want.value = stored_vals[slot];
      end
    end else if (v == VAL_NONE) begin
      want.status = ST_INVALID;
    end else if (slot >= 0) begin
      want.found = 1'b1;
      want.value = stored_vals[slot];
      want.status = ST_DUP;
    end else if (stored_count >= DEPTH) begin
      want.status = ST_FULL;
    end else begin
      stored_keys[stored_count] = k;
      stored_vals[stored_count] = v;
      stored_count++;
      want.found = 1'b1;
      want.value = v;
    end
    want.count = CNT_OUT_W'(stored_count);
    pending_results.push_back(want);
    in_valid <= 1'b1;
    req_type <= req;
    key <= k;
    value_in <= v;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    int pick;
    logic [KEY_W-1:0] k;
    pick = $urandom_range(0, 99);
    k = (stored_count > 0) ? stored_keys[$urandom_range(0, stored_count - 1)] : $urandom;
    if (pick < 40) send_request(REQ_FIND, k, $urandom);
    else if (pick < 52) send_request(REQ_FIND, $urandom, $urandom);
    else if (pick < 67) send_request(REQ_APPEND, k, $urandom_range(0, 32'hFFFF_FFFE));
    else if (pick < 80) send_request(REQ_APPEND, fresh_key(), $urandom_range(0, 32'hFFFF_FFFE));
    else if (pick < 86) send_request(1'($urandom_range(0, 1)), KEY_INVALID, $urandom);
    else if (pick < 91) send_request(REQ_APPEND, $urandom_range(0, 1) ? k : fresh_key(), VAL_NONE);
    else send_request(1'($urandom_range(0, 1)), $urandom, $urandom);
  endtask

  task automatic test_empty_table();
    send_request(REQ_FIND, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_FIND, KEY_INVALID, VAL_NONE);
    send_request(REQ_APPEND, KEY_INVALID, 32'h0000_0005);
    send_request(REQ_APPEND, 32'h0000_0007, VAL_NONE);
    send_request(REQ_FIND, 32'h0000_0007, 32'h0000_0000);
  endtask

  task automatic test_append_find();
    send_request(REQ_APPEND, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_APPEND, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
    send_request(REQ_APPEND, 32'h8000_0000, 32'h1234_5678);
    send_request(REQ_FIND, 32'h0000_0000, VAL_NONE);
    send_request(REQ_FIND, 32'hFFFF_FFFE, 32'h0000_0000);
    send_request(REQ_FIND, 32'h8000_0000, 32'h0000_0000);
    send_request(REQ_APPEND, 32'h0000_0000, 32'h5555_AAAA);
    send_request(REQ_APPEND, 32'h8000_0000, VAL_NONE);
    send_request(REQ_FIND, 32'h0000_0001, 32'h0000_0000);
    send_request(REQ_FIND, KEY_INVALID, 32'h0000_0000);
    send_request(REQ_APPEND, 32'h7FFF_FFFF, 32'h0000_0001);
    send_request(REQ_FIND, 32'h7FFF_FFFF, 32'h0000_0000);
    send_request(REQ_FIND, 32'h0000_0000, 32'h0000_0000);
  endtask

  task automatic test_random_mix();
    for (int chunk = 0; chunk < 10; chunk++) begin
      case (chunk % 4)
        0: begin tx_max_gap = 3; rx_max_hold = 3; end
        1: begin tx_max_gap = 0; rx_max_hold = 0; end
        2: begin tx_max_gap = 3; rx_max_hold = 0; end
        default: begin tx_max_gap = 0; rx_max_hold = 3; end
      endcase
      for (int n = 0; n < 100; n++) send_random_request();
      if (chunk == 4) wait_for_results();
    end
  endtask

  task automatic test_full_table();
    tx_max_gap = 1;
    rx_max_hold = 3;
    while (stored_count < DEPTH) begin
      send_request(REQ_APPEND, fresh_key(), $urandom_range(0, 32'hFFFF_FFFE));
    end
    send_request(REQ_FIND, stored_keys[DEPTH-1], 32'h0000_0000);
    send_request(REQ_FIND, stored_keys[0], 32'h0000_0000);
    for (int n = 0; n < 8; n++) begin
      send_request(REQ_APPEND, fresh_key(), $urandom_range(0, 32'hFFFF_FFFE));
    end
    send_request(REQ_APPEND, stored_keys[DEPTH-1], 32'h0000_0000);
    send_request(REQ_APPEND, fresh_key(), VAL_NONE);
    send_request(REQ_APPEND, KEY_INVALID, 32'h0000_0000);
    send_request(REQ_FIND, fresh_key(), 32'h0000_0000);
    for (int n = 0; n < 20; n++) send_random_request();
  endtask

  // result side: random stall after each taken result, in-order compare
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: found %0d value_out %h status %0d entry_count %0d",
                 found, value_out, status, entry_count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, found);
            errors++;
          end
          if (value_out !== want.value) begin
            $error("value_out: expected %h, actual %h", want.value, value_out);
            errors++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            errors++;
          end
          if (entry_count !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count, entry_count);
            errors++;
          end
        end
        hold_left = $urandom_range(0, rx_max_hold);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_stall <= (hold_left != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_append_find();
    wait_for_results();
    test_random_mix();
    test_full_table();
    wait_for_results();
    repeat (DEPTH + 16) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
